### rtl/cbu_pkg.sv
// ----------------------------------------------------------------------------
// cbu_pkg
// Shared types, fixed-point constants and helpers for the color blend unit.
// ----------------------------------------------------------------------------
package cbu_pkg;

  localparam int FIELD_W   = 16;              // port field width
  localparam int FRAC_BITS = 15;              // fraction bits, ONE = 1.0
  localparam int CH_W      = FRAC_BITS + 1;   // holds 0..ONE
  localparam int PROD_W    = 2 * CH_W;        // full product width
  localparam int MODE_W    = 4;

  typedef logic [FIELD_W-1:0] field_t;
  typedef logic [CH_W-1:0]    chan_t;
  typedef logic [PROD_W-1:0]  prod_t;

  localparam chan_t ONE     = chan_t'(1 << FRAC_BITS);
  localparam chan_t HALF    = chan_t'(1 << (FRAC_BITS - 1));
  localparam chan_t QUARTER = chan_t'(1 << (FRAC_BITS - 2));

  typedef enum logic [MODE_W-1:0] {
    MODE_MULTIPLY   = 4'd0,
    MODE_ADD        = 4'd1,
    MODE_SUBTRACT   = 4'd2,
    MODE_DIFFERENCE = 4'd3,
    MODE_SCREEN     = 4'd4,
    MODE_OVERLAY    = 4'd5,
    MODE_LIGHTEN    = 4'd6,
    MODE_DARKEN     = 4'd7,
    MODE_COLOR      = 4'd8
  } mode_t;

  localparam logic [MODE_W-1:0] MODE_LAST = MODE_W'(MODE_COLOR);

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    chan_t alpha;
  } rgba_t;

  // clamp an incoming field to 1.0
  function automatic chan_t sat_one(input field_t v);
    if (PROD_W'(v) > PROD_W'(ONE)) return ONE;
    return chan_t'(v);
  endfunction

  // rounded fixed-point product
  function automatic chan_t fx_mul(input chan_t x, input chan_t y);
    prod_t p;
    p = PROD_W'(x) * PROD_W'(y) + PROD_W'(HALF);
    return chan_t'(p >> FRAC_BITS);
  endfunction

endpackage

### rtl/cbu_channel.sv
// ----------------------------------------------------------------------------
// cbu_channel
// One color channel blend: a single shared multiplier plus add/compare logic.
// ----------------------------------------------------------------------------
module cbu_channel (
  input  logic [cbu_pkg::MODE_W-1:0] mode,
  input  cbu_pkg::chan_t             a,
  input  cbu_pkg::chan_t             b,
  output cbu_pkg::chan_t             y
);
  import cbu_pkg::*;

  logic               a_low;
  logic               a_gt;
  logic               use_inv;
  chan_t              op_a;
  chan_t              op_b;
  prod_t              prod;
  chan_t              q_mul;
  chan_t              q_dbl;
  logic [CH_W:0]      sum;
  chan_t              sum_sat;
  chan_t              diff_ab;
  chan_t              diff_ba;

  assign a_low = a < HALF;
  assign a_gt  = a > b;

  // screen and the upper half of overlay work on the complements
  assign use_inv = (mode == MODE_W'(MODE_SCREEN)) ||
                   ((mode == MODE_W'(MODE_OVERLAY)) && !a_low);
  assign op_a    = use_inv ? ONE - a : a;
  assign op_b    = use_inv ? ONE - b : b;
  assign prod    = PROD_W'(op_a) * PROD_W'(op_b);

  assign q_mul   = chan_t'((prod + PROD_W'(HALF)) >> FRAC_BITS);
  assign q_dbl   = chan_t'((prod + PROD_W'(QUARTER)) >> (FRAC_BITS - 1));

  assign sum     = {1'b0, a} + {1'b0, b};
  assign sum_sat = (sum > {1'b0, ONE}) ? ONE : sum[CH_W-1:0];
  assign diff_ab = a - b;
  assign diff_ba = b - a;

  always_comb begin
    unique case (mode_t'(mode))
      MODE_MULTIPLY:   y = q_mul;
      MODE_ADD:        y = sum_sat;
      MODE_SUBTRACT:   y = a_gt ? diff_ab : '0;
      MODE_DIFFERENCE: y = a_gt ? diff_ab : diff_ba;
      MODE_SCREEN:     y = ONE - q_mul;
      MODE_OVERLAY:    y = a_low ? q_dbl : ONE - q_dbl;
      MODE_LIGHTEN:    y = a_gt ? a : b;
      MODE_DARKEN:     y = a_gt ? b : a;
      MODE_COLOR:      y = b;
      default:         y = ONE;
    endcase
  end

endmodule

### rtl/color_blend_unit_core.sv
// ----------------------------------------------------------------------------
// color_blend_unit_core
// RGBA blend of two colors per channel under a configured blend mode.
// ----------------------------------------------------------------------------
//  channel  signals                        direction  notes
//  in       in_valid/in_ready, a_*, b_*    into core  one color pair per item
//  out      out_valid/out_ready, out_*     from core  one blended color per item
//  cfg      cfg_valid/cfg_ready, cfg_data  into core  blend_mode, always ready
//
//  Two register stages: the input register holds the clamped channels, the
//  output register holds the blended result. One item is taken every cycle
//  while the output is not stalled; a single multiplier per channel sits
//  between those two registers.
//  Reset clears both stage valids and sets the mode to multiply.
//  A stalled output holds its item; the input stage takes one more item only
//  if it is empty, otherwise in_ready drops in the same cycle as out_ready.
// ----------------------------------------------------------------------------
module color_blend_unit_core (
  input  logic                        clk,
  input  logic                        rst,
  // input items
  input  logic                        in_valid,
  output logic                        in_ready,
  input  cbu_pkg::field_t             a_red,
  input  cbu_pkg::field_t             a_green,
  input  cbu_pkg::field_t             a_blue,
  input  cbu_pkg::field_t             a_alpha,
  input  cbu_pkg::field_t             b_red,
  input  cbu_pkg::field_t             b_green,
  input  cbu_pkg::field_t             b_blue,
  input  cbu_pkg::field_t             b_alpha,
  // result items
  output logic                        out_valid,
  input  logic                        out_ready,
  output cbu_pkg::field_t             out_red,
  output cbu_pkg::field_t             out_green,
  output cbu_pkg::field_t             out_blue,
  output cbu_pkg::field_t             out_alpha,
  // mode register write
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [cbu_pkg::MODE_W-1:0]  cfg_data
);
  import cbu_pkg::*;

  logic [MODE_W-1:0] mode;      // blend_mode register

  // input stage
  logic  s1_valid;
  rgba_t a_q;
  rgba_t b_q;
  logic  s1_adv;                // stage 1 item moves to the output register
  logic  out_load;              // output register may take a new item

  // blended channels between the stages
  chan_t red_y;
  chan_t green_y;
  chan_t blue_y;
  chan_t alpha_y;

  assign cfg_ready = 1'b1;

  assign out_load = !out_valid || out_ready;
  assign s1_adv   = s1_valid && out_load;
  assign in_ready = !s1_valid || s1_adv;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      mode      <= MODE_W'(MODE_MULTIPLY);
    end else begin
      if (in_ready) s1_valid <= in_valid;
      if (out_load) out_valid <= s1_valid;
      if (cfg_valid && cfg_ready) mode <= cfg_data;
    end
  end

  // input register: clamp every channel to 1.0 on the way in
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_q <= '{red: sat_one(a_red), green: sat_one(a_green),
               blue: sat_one(a_blue), alpha: sat_one(a_alpha)};
      b_q <= '{red: sat_one(b_red), green: sat_one(b_green),
               blue: sat_one(b_blue), alpha: sat_one(b_alpha)};
    end
  end

  cbu_channel u_red (
    .mode (mode),
    .a    (a_q.red),
    .b    (b_q.red),
    .y    (red_y)
  );

  cbu_channel u_green (
    .mode (mode),
    .a    (a_q.green),
    .b    (b_q.green),
    .y    (green_y)
  );

  cbu_channel u_blue (
    .mode (mode),
    .a    (a_q.blue),
    .b    (b_q.blue),
    .y    (blue_y)
  );

  // alpha is the plain product in every defined mode; unused modes give 1.0
  assign alpha_y = (mode > MODE_LAST) ? ONE : fx_mul(a_q.alpha, b_q.alpha);

  // output register
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_red   <= FIELD_W'(red_y);
      out_green <= FIELD_W'(green_y);
      out_blue  <= FIELD_W'(blue_y);
      out_alpha <= FIELD_W'(alpha_y);
    end
  end

  // ---- checks ---------------------------------------------------------------

  // input back pressure only comes from a stalled output register
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !in_ready) |-> (out_valid && !out_ready))
    else $error("input stalled without output back pressure");

  // an accepted item into an empty input stage is held there next cycle
  a_s1_fill: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !s1_valid) |=> s1_valid)
    else $error("accepted item lost in input stage");

  // an item leaving stage 1 shows up at the output
  a_s1_to_out: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> out_valid)
    else $error("stage 1 item did not reach output register");

endmodule
